// ===== hw/rtl/fermat_primality_test_macros.svh =====
// assertion macros for the fermat primality test block
// used by the modules that carry concurrent checks
`ifndef FERMAT_PRIMALITY_TEST_MACROS_SVH
`define FERMAT_PRIMALITY_TEST_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FPT_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("check failed");
`define FPT_ASSERT_NR(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("check failed");
`else
`define FPT_ASSERT(label, clk, rst, prop)
`define FPT_ASSERT_NR(label, clk, prop)
`endif
`endif

// ===== hw/rtl/fpt_pkg.sv =====
// shared constants for the fermat primality test block
// no dependencies
`default_nettype none
package fpt_pkg;
  localparam int unsigned WIDTH_DEFAULT = 32;
  localparam int unsigned FIELD_W = 32;
endpackage
`default_nettype wire

// ===== hw/rtl/fermat_primality_test.sv =====
// Fermat primality test, one base per input transfer, one result per base.
// Work for an item runs through the bit-serial datapaths: the gcd takes Euclid
// steps through the divider, up to about 46 steps for 32-bit operands; one
// more division reduces the base mod the candidate; the power then takes two
// modular products per exponent bit, each worked one multiplier bit at a time.
// One item is in work at a time; the result sits in an output register, and
// the next transfer is not taken while that result is held by out_stall.
// Candidate and base use their low WIDTH bits.
`default_nettype none
`include "fermat_primality_test_macros.svh"
module fermat_primality_test #(
  parameter int unsigned WIDTH = fpt_pkg::WIDTH_DEFAULT
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [fpt_pkg::FIELD_W-1:0]   candidate,
  input  wire logic [fpt_pkg::FIELD_W-1:0]   base,
  input  wire logic                          last_base,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               base_coprime,
  output logic                               base_is_witness,
  output logic                               probably_prime,
  output logic                               run_done
);
  localparam logic [2:0] S_IDLE = 3'd0, S_GCD = 3'd1, S_GWAIT = 3'd2,
    S_RED = 3'd3, S_POW = 3'd4, S_MWAIT = 3'd5, S_DONE = 3'd6;
  localparam int unsigned KW = (WIDTH < fpt_pkg::FIELD_W) ? WIDTH : fpt_pkg::FIELD_W;

  logic [2:0]       state;
  logic [WIDTH-1:0] cand, bse, gx, gy, res, sq, ex;
  logic             last, coprime, witness_seen, phase_sq;
  logic [WIDTH-1:0] cand_in, base_in;
  logic             div_start, div_done, mul_start, mul_done;
  logic [WIDTH-1:0] div_a, div_d, div_rem, mul_x, mul_y, mul_p;
  logic             witness;

  assign cand_in = WIDTH'(candidate[KW-1:0]);
  assign base_in = WIDTH'(base[KW-1:0]);
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);

  fpt_divider #(.WIDTH(WIDTH)) u_div (
    .clk, .rst, .start(div_start), .a(div_a), .d(div_d), .done(div_done), .rem(div_rem)
  );
  fpt_modmul #(.WIDTH(WIDTH)) u_mul (
    .clk, .rst, .start(mul_start), .x(mul_x), .y(mul_y), .m(cand),
    .done(mul_done), .prod(mul_p)
  );

  assign div_a = (state == S_RED) ? bse : gx;
  assign div_d = (state == S_RED) ? cand : gy;
  assign div_start = ((state == S_GCD) && (gy != '0)) || (state == S_RED && cand != '0);
  assign mul_start = (state == S_POW) && (ex != '0);
  assign mul_x = phase_sq ? sq : res;
  assign mul_y = sq;
  assign witness = coprime && (res != WIDTH'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      witness_seen <= 1'b0;
    end else begin
      if (state == S_DONE && (!out_valid || !out_stall)) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cand  <= cand_in;
            bse   <= base_in;
            last  <= last_base;
            gx    <= cand_in;
            gy    <= base_in;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (gy == '0) begin
            coprime <= (gx == WIDTH'(1));
            state   <= S_RED;
          end else begin
            state <= S_GWAIT;
          end
        end
        S_GWAIT: begin
          if (div_done) begin
            gx    <= gy;
            gy    <= div_rem;
            state <= S_GCD;
          end
        end
        S_RED: begin
          // residue 0 stands for the missing residue of candidate zero
          res <= (cand == WIDTH'(1) || cand == '0) ? '0 : WIDTH'(1);
          ex  <= cand - WIDTH'(1);
          phase_sq <= 1'b0;
          state <= (cand == '0) ? S_DONE : S_MWAIT;
        end
        S_MWAIT: begin
          if (div_done) begin
            sq    <= div_rem;
            state <= S_POW;
          end else if (mul_done) begin
            if (!phase_sq) begin
              if (ex[0]) res <= mul_p;
              phase_sq <= 1'b1;
              state    <= S_POW;
            end else begin
              sq       <= mul_p;
              ex       <= ex >> 1;
              phase_sq <= 1'b0;
              state    <= S_POW;
            end
          end
        end
        S_POW: begin
          if (ex == '0) state <= S_DONE;
          else state <= S_MWAIT;
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            base_coprime    <= coprime;
            base_is_witness <= witness;
            probably_prime  <= !(witness_seen || witness) && (cand != '0);
            run_done        <= last;
            witness_seen    <= last ? 1'b0 : (witness_seen || witness);
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `FPT_ASSERT(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(base_is_witness))
  `FPT_ASSERT(a_wit_cop, clk, rst, out_valid |-> !base_is_witness || base_coprime)
  `FPT_ASSERT(a_busy_stall, clk, rst, state != S_IDLE |-> in_stall)
  `FPT_ASSERT(a_zero_comp, clk, rst, out_valid && base_is_witness |-> !probably_prime)
endmodule
`default_nettype wire

// ===== hw/rtl/fpt_modmul.sv =====
// bit-serial modular multiplier: (x * y) mod m, one multiplier bit per cycle
// depends on nothing; x must already be below m
`default_nettype none
module fpt_modmul #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] x,
  input  wire logic [WIDTH-1:0] y,
  input  wire logic [WIDTH-1:0] m,
  output logic                  done,
  output logic [WIDTH-1:0]      prod
);
  logic             busy;
  logic [WIDTH-1:0] acc;
  logic [WIDTH-1:0] cur;
  logic [WIDTH-1:0] yr;
  logic [WIDTH-1:0] acc_next;
  logic [WIDTH-1:0] cur_next;

  // add modulo m without overflow, operands below m
  always_comb begin
    acc_next = acc;
    if (yr[0]) begin
      if (acc >= m - cur) acc_next = acc - (m - cur);
      else acc_next = acc + cur;
    end
    if (cur >= m - cur) cur_next = cur - (m - cur);
    else cur_next = cur + cur;
  end

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (yr == '0);
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      acc  <= '0;
      cur  <= x;
      yr   <= y;
    end else if (busy) begin
      if (yr == '0) begin
        busy <= 1'b0;
      end else begin
        acc <= acc_next;
        cur <= cur_next;
        yr  <= yr >> 1;
      end
    end
  end
  assign prod = acc;
endmodule
`default_nettype wire

// ===== hw/rtl/fpt_divider.sv =====
// restoring divider for the remainder a mod d, one quotient bit per cycle
// depends on nothing; d must be nonzero
`default_nettype none
module fpt_divider #(
  parameter int unsigned WIDTH = 32
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [WIDTH-1:0] a,
  input  wire logic [WIDTH-1:0] d,
  output logic                  done,
  output logic [WIDTH-1:0]      rem
);
  localparam int unsigned CW = $clog2(WIDTH + 1);
  logic             busy;
  logic [CW-1:0]    cnt;
  logic [WIDTH-1:0] num;
  logic [WIDTH-1:0] dv;
  logic [WIDTH:0]   r;
  logic [WIDTH:0]   trial;

  assign trial = {r[WIDTH-1:0], num[WIDTH-1]};

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (cnt == '0);
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(WIDTH);
      num  <= a;
      dv   <= d;
      r    <= '0;
    end else if (busy) begin
      if (cnt == '0) begin
        busy <= 1'b0;
      end else begin
        num <= num << 1;
        cnt <= cnt - 1'b1;
        if (trial >= {1'b0, dv}) r <= trial - {1'b0, dv};
        else r <= trial;
      end
    end
  end
  assign rem = r[WIDTH-1:0];
endmodule
`default_nettype wire

// ===== bench/fermat_primality_test_tb.sv =====
// testbench for the fermat primality test block: directed and random bases,
// self-computed expected flags and verdict, random idling on both sides
// depends on fpt_pkg and fermat_primality_test
`timescale 1ns / 100ps
`default_nettype none
module fermat_primality_test_tb;

  localparam int unsigned W = fpt_pkg::WIDTH_DEFAULT;
  localparam int HOLD_LEN = 12000;

  typedef struct packed {
    logic coprime;
    logic witness;
    logic prime;
    logic done;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [fpt_pkg::FIELD_W-1:0] candidate = '0;
  logic [fpt_pkg::FIELD_W-1:0] base = '0;
  logic last_base = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic base_coprime, base_is_witness, probably_prime, run_done;

  verdict_t verdicts_due[$];
  logic witness_seen_q = 1'b0;
  int errors = 0;
  bit sender_idles = 1'b1;
  bit receiver_idles = 1'b1;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_cycles = 0;
  int idle_left = 0;

  fermat_primality_test #(.WIDTH(W)) u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .candidate(candidate), .base(base), .last_base(last_base),
    .out_valid(out_valid), .out_stall(out_stall),
    .base_coprime(base_coprime), .base_is_witness(base_is_witness),
    .probably_prime(probably_prime), .run_done(run_done)
  );

  always #5 clk = ~clk;

  // (a*b) mod m with a 128-bit product, m > 0
  function automatic logic [63:0] mulmod(logic [63:0] a, logic [63:0] b, logic [63:0] m);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p % {64'd0, m});
  endfunction

  function automatic logic [63:0] powmod(logic [63:0] b, logic [63:0] e, logic [63:0] m);
    logic [63:0] r;
    logic [63:0] sq;
    r = 64'd1 % m;
    sq = b % m;
    while (e != 0) begin
      if (e[0]) r = mulmod(r, sq, m);
      sq = mulmod(sq, sq, m);
      e = e >> 1;
    end
    return r;
  endfunction

  function automatic logic [63:0] gcd(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic verdict_t judge_base(logic [31:0] c, logic [31:0] b, logic lst);
    verdict_t v;
    logic [63:0] cm, bm, res;
    cm = 64'(c) & ((64'd1 << W) - 1);
    bm = 64'(b) & ((64'd1 << W) - 1);
    res = 0;
    v.coprime = gcd(cm, bm) == 1;
    if (cm != 0) res = powmod(bm, cm - 1, cm);
    v.witness = v.coprime && res != 1;
    if (v.witness) witness_seen_q = 1'b1;
    v.prime = !witness_seen_q && cm != 0;
    v.done = lst;
    if (lst) witness_seen_q = 1'b0;
    return v;
  endfunction

  task automatic send_base(logic [31:0] c, logic [31:0] b, logic lst);
    if (sender_idles && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    in_valid <= 1'b1;
    candidate <= c;
    base <= b;
    last_base <= lst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdicts_due.push_back(judge_base(c, b, lst));
  endtask

  // stall generator: random bursts, and a long hold-off on request
  always @(posedge clk) begin
    if (hold_requests != hold_seen) begin
      hold_seen <= hold_requests;
      hold_cycles <= HOLD_LEN - 1;
      out_stall <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_stall <= 1'b1;
    end else if (idle_left > 0) begin
      idle_left <= idle_left - 1;
      out_stall <= 1'b1;
    end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
      idle_left <= int'($urandom_range(0, 15));
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    verdict_t v;
    if (!rst && out_valid && !out_stall) begin
      if (verdicts_due.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        v = verdicts_due.pop_front();
        if (base_coprime !== v.coprime) begin
          $error("base_coprime exp %0b got %0b", v.coprime, base_coprime); errors++;
        end
        if (base_is_witness !== v.witness) begin
          $error("base_is_witness exp %0b got %0b", v.witness, base_is_witness); errors++;
        end
        if (probably_prime !== v.prime) begin
          $error("probably_prime exp %0b got %0b", v.prime, probably_prime); errors++;
        end
        if (run_done !== v.done) begin
          $error("run_done exp %0b got %0b", v.done, run_done); errors++;
        end
      end
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (verdicts_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_candidate();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 3);
      1: return $urandom;
      2: return $urandom_range(2, 200);
      3: return 32'd561;
      4: return 32'hFFFF_FFFB;
      default: return $urandom_range(2, 100000) | 32'd1;
    endcase
  endfunction

  task automatic test_directed();
    send_base(32'd0, 32'd0, 1'b0);
    send_base(32'd0, 32'd1, 1'b1);
    send_base(32'd1, 32'd0, 1'b0);
    send_base(32'd1, 32'hFFFF_FFFF, 1'b1);
    send_base(32'd2, 32'd0, 1'b0);
    send_base(32'd2, 32'd1, 1'b1);
    send_base(32'd97, 32'd2, 1'b0);
    send_base(32'd97, 32'd96, 1'b0);
    send_base(32'd97, 32'hFFFF_FFFF, 1'b1);
    send_base(32'd561, 32'd2, 1'b0);
    send_base(32'd561, 32'd3, 1'b1);
    send_base(32'd15, 32'd2, 1'b0);
    send_base(32'd15, 32'd4, 1'b1);
    send_base(32'hFFFF_FFFB, 32'd2, 1'b0);
    send_base(32'hFFFF_FFFB, 32'hFFFF_FFFA, 1'b1);
    send_base(32'hFFFF_FFFF, 32'hFFFF_FFFE, 1'b1);
    send_base(32'h8000_0000, 32'h5555_5555, 1'b1);
    send_base(32'h7FFF_FFFF, 32'hAAAA_AAAA, 1'b1);
  endtask

  task automatic test_random_runs(int n_items);
    logic [31:0] c;
    int left;
    int done_items;
    done_items = 0;
    while (done_items < n_items) begin
      c = pick_candidate();
      left = $urandom_range(1, 6);
      while (left > 0 && done_items < n_items) begin
        left--;
        done_items++;
        send_base(c, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom,
                  left == 0 || $urandom_range(0, 15) == 0);
      end
    end
  endtask

  // receiver holds off longer than two items take, so the block fills up
  task automatic test_backpressure();
    hold_requests++;
    repeat (6) send_base(pick_candidate(), $urandom, 1'($urandom_range(0, 1)));
    wait_drained();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    wait_drained();
    test_backpressure();
    test_random_runs(90);
    // sender pauses until everything is back
    wait_drained();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random_runs(30);
    wait_drained();
    repeat (50) @(posedge clk);
    if (errors == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #40ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fpt_pkg.sv
hw/rtl/fpt_modmul.sv
hw/rtl/fpt_divider.sv
hw/rtl/fermat_primality_test.sv
bench/fermat_primality_test_tb.sv
